// ===== src/hrd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types, codes and defaults for the hot ring detector.
// ----------------------------------------------------------------------------
package hrd_pkg;

  // Ring count default and storage widths.
  localparam int NUM_RINGS_DEF = 4;
  localparam int SPEC_W        = 4;   // holds any ring index or the "none" code
  localparam int CNT_W         = 32;
  localparam int TOT_W         = 64;
  localparam int THR_W         = 13;
  localparam int MIN_W         = 16;
  localparam int MASK_W        = 4;
  localparam int TAG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int PP_W          = 32 + THR_W;          // one partial product
  localparam int PROD_W        = TOT_W + THR_W;       // full threshold product

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECLARED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWERING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYC_TAG  = 3'd4;

  // Configuration reset values.
  localparam logic [MIN_W-1:0]  MIN_INV_RST  = 16'd16;
  localparam logic [THR_W-1:0]  HOT_THR_RST  = 13'd2867;
  localparam logic [MASK_W-1:0] DECLARED_RST = 4'hF;
  localparam logic [MASK_W-1:0] LOWERING_RST = 4'hF;
  localparam logic [TAG_W-1:0]  CYC_TAG_RST  = 16'd0;

  // Operation codes.
  localparam logic [1:0] OP_OBSERVE      = 2'd0;
  localparam logic [1:0] OP_SPECIALIZE   = 2'd1;
  localparam logic [1:0] OP_DESPECIALIZE = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ALREADY = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_NONE    = 2'd3;

  // Witness kinds.
  localparam logic WIT_SPECIALIZE   = 1'b0;
  localparam logic WIT_DESPECIALIZE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take an input item and apply its update
    logic scan_step;  // visit one ring counter
    logic finish;     // decide the hot ring and load the output register
  } hrd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan is at the last ring
    logic out_free;   // the output register can take a new item
  } hrd_sts_t;

endpackage

// ===== src/hrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hrd_ctrl
// Sequencer: accept an item, scan the ring counters, then decide and
// hand the result to the output register.
// ----------------------------------------------------------------------------
module hrd_ctrl
  import hrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output hrd_cmd_t cmd,
  input  hrd_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Handshake and commands.
  assign in_ready      = (state == ST_IDLE);
  assign cmd.load      = in_valid && (state == ST_IDLE);
  assign cmd.scan_step = (state == ST_SCAN);
  assign cmd.finish    = (state == ST_DONE) && sts.out_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/hrd_datapath.sv =====
// ----------------------------------------------------------------------------
// hrd_datapath
// Configuration registers, ring counters, total, specialization state,
// the argmax scan, the threshold product pipeline and the output register.
// ----------------------------------------------------------------------------
module hrd_datapath
  import hrd_pkg::*;
#(
  parameter int NUM_RINGS = NUM_RINGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]            operation,
  input  logic [2:0]            ring,
  input  hrd_cmd_t              cmd,
  output hrd_sts_t              sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [1:0]            status,
  output logic                  hot_valid,
  output logic [1:0]            hot_ring,
  output logic                  witness_valid,
  output logic                  witness_kind,
  output logic [1:0]            witness_ring,
  output logic [TAG_W-1:0]      witness_tag,
  output logic [2:0]            current_special_ring
);

  localparam int RING_W = $clog2(NUM_RINGS);
  localparam logic [SPEC_W-1:0] SPEC_NONE = SPEC_W'(NUM_RINGS);
  localparam logic [RING_W-1:0] LAST_RING = RING_W'(NUM_RINGS - 1);

  // Configuration registers.
  logic [MIN_W-1:0]  min_inv;
  logic [THR_W-1:0]  hot_thr;
  logic [MASK_W-1:0] declared_mask;
  logic [MASK_W-1:0] lowering_mask;
  logic [TAG_W-1:0]  cycle_tag;

  // Counting and specialization state.
  logic [CNT_W-1:0]  ring_counts [NUM_RINGS];
  logic [TOT_W-1:0]  total_count;
  logic [SPEC_W-1:0] special_ring;

  // Item decode.
  logic ring_ok;
  logic lowered;
  logic declared;
  logic count_it;

  // Per-item result under construction.
  logic [1:0]        res_status;
  logic              res_wv;
  logic              res_wk;
  logic [1:0]        res_wr;
  logic [TAG_W-1:0]  res_wt;
  logic [1:0]        res_status_next;
  logic              res_wv_next;
  logic              res_wk_next;
  logic [1:0]        res_wr_next;
  logic [SPEC_W-1:0] special_ring_next;

  // Scan registers.
  logic [RING_W-1:0] scan_idx;
  logic [CNT_W-1:0]  best;
  logic [RING_W-1:0] best_r;
  logic              found;
  logic [CNT_W-1:0]  scan_val;

  // Threshold product pipeline.
  logic [PP_W-1:0]   pp_lo;
  logic [PP_W-1:0]   pp_hi;
  logic [PROD_W-1:0] prod;
  logic              hot_pass;
  logic [2:0]        best_r_ext;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_inv       <= MIN_INV_RST;
      hot_thr       <= HOT_THR_RST;
      declared_mask <= DECLARED_RST;
      lowering_mask <= LOWERING_RST;
      cycle_tag     <= CYC_TAG_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_INV:  min_inv       <= cfg_wdata;
        REG_HOT_THR:  hot_thr       <= cfg_wdata[THR_W-1:0];
        REG_DECLARED: declared_mask <= cfg_wdata[MASK_W-1:0];
        REG_LOWERING: lowering_mask <= cfg_wdata[MASK_W-1:0];
        REG_CYC_TAG:  cycle_tag     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Ring checks. Rings at four and above have no mask bit.
  assign ring_ok  = SPEC_W'(ring) < SPEC_NONE;
  assign lowered  = !ring[2] && lowering_mask[ring[1:0]];
  assign declared = !ring[2] && declared_mask[ring[1:0]];
  assign count_it = cmd.load && (operation == OP_OBSERVE) && ring_ok && lowered;

  // One saturating counter lane per ring.
  for (genvar i = 0; i < NUM_RINGS; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (rst) begin
        ring_counts[i] <= '0;
      end else if (count_it && (ring == 3'(i)) && (ring_counts[i] != '1)) begin
        ring_counts[i] <= ring_counts[i] + 1'b1;
      end
    end
  end

  // Saturating total.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
    end else if (count_it && (total_count != '1)) begin
      total_count <= total_count + 1'b1;
    end
  end

  // Specialize and despecialize decisions.
  always_comb begin
    res_status_next   = STAT_OK;
    res_wv_next       = 1'b0;
    res_wk_next       = WIT_SPECIALIZE;
    res_wr_next       = 2'd0;
    special_ring_next = special_ring;
    case (operation)
      OP_OBSERVE: begin
      end
      OP_SPECIALIZE: begin
        if (!ring_ok || !declared) begin
          res_status_next = STAT_INVALID;
        end else if (special_ring == SPEC_W'(ring)) begin
          res_status_next = STAT_ALREADY;
        end else begin
          special_ring_next = SPEC_W'(ring);
          res_wv_next       = 1'b1;
          res_wr_next       = ring[1:0];
        end
      end
      OP_DESPECIALIZE: begin
        if (special_ring == SPEC_NONE) begin
          res_status_next = STAT_NONE;
        end else begin
          special_ring_next = SPEC_NONE;
          res_wv_next       = 1'b1;
          res_wk_next       = WIT_DESPECIALIZE;
          res_wr_next       = special_ring[1:0];
        end
      end
      default: begin
        res_status_next = STAT_INVALID;
      end
    endcase
  end

  // Specialized ring register.
  always_ff @(posedge clk) begin
    if (rst) begin
      special_ring <= SPEC_NONE;
    end else if (cmd.load) begin
      special_ring <= special_ring_next;
    end
  end

  // Hold the item's status and witness until the result is loaded.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= res_status_next;
      res_wv     <= res_wv_next;
      res_wk     <= res_wk_next;
      res_wr     <= res_wr_next;
      res_wt     <= res_wv_next ? cycle_tag : '0;
    end
  end

  // Argmax scan: one counter per cycle, first strict maximum wins.
  assign scan_val = ring_counts[scan_idx];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx <= '0;
      best     <= '0;
      best_r   <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (scan_val > best) begin
        best   <= scan_val;
        best_r <= scan_idx;
        found  <= 1'b1;
      end
    end
  end

  assign sts.scan_last = (scan_idx == LAST_RING);

  // Threshold product total * q in two 32-bit halves, then one wide add.
  // The total is stable from the accept edge; pp_lo/pp_hi and then prod
  // register the product before the scan of at least two rings has ended.
  always_ff @(posedge clk) begin
    pp_lo <= PP_W'(total_count[31:0]) * PP_W'(hot_thr);
    pp_hi <= PP_W'(total_count[TOT_W-1:32]) * PP_W'(hot_thr);
    prod  <= {pp_hi, 32'd0} + PROD_W'(pp_lo);
  end

  // Hot test: a ring was found, total >= min_inv, and best * 4096 > total * q at full width.
  assign hot_pass = found
                 && (total_count >= TOT_W'(min_inv))
                 && (PROD_W'({best, 12'd0}) > prod);
  assign best_r_ext = 3'(best_r);

  // Output register.
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status               <= res_status;
      hot_valid            <= hot_pass;
      hot_ring             <= hot_pass ? best_r_ext[1:0] : 2'd0;
      witness_valid        <= res_wv;
      witness_kind         <= res_wk;
      witness_ring         <= res_wr;
      witness_tag          <= res_wt;
      current_special_ring <= special_ring[2:0];
    end
  end

endmodule

// ===== src/hot_ring_detector.sv =====
// ----------------------------------------------------------------------------
// hot_ring_detector
// Per-ring invocation counters with a hottest-ring report and
// specialization tracking with witness events.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------------------------
//   in       in_valid/in_ready    operation, ring
//   out      out_valid/out_ready  status, hot_valid, hot_ring, witness_valid,
//                                 witness_kind, witness_ring, witness_tag,
//                                 current_special_ring
//   cfg      cfg_wr_en            cfg_index, cfg_wdata
//
// An item is accepted and updates the counters, the argmax scan then
// visits the counters ring by ring, and last comes the threshold
// decision.
// Reset clears all counters and the specialized ring; there is no clearing
// pass. A stalled output holds the next item in its decision cycle until
// the output register frees up; a new item is accepted meanwhile only once
// the previous one has reached the output register.
module hot_ring_detector
  import hrd_pkg::*;
#(
  parameter int NUM_RINGS = NUM_RINGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic [2:0]            ring,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic                  hot_valid,
  output logic [1:0]            hot_ring,
  output logic                  witness_valid,
  output logic                  witness_kind,
  output logic [1:0]            witness_ring,
  output logic [TAG_W-1:0]      witness_tag,
  output logic [2:0]            current_special_ring
);

  hrd_cmd_t cmd;
  hrd_sts_t sts;

  // Sequencer.
  hrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Counters, scan, threshold and output register.
  hrd_datapath #(
    .NUM_RINGS (NUM_RINGS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .operation            (operation),
    .ring                 (ring),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .status               (status),
    .hot_valid            (hot_valid),
    .hot_ring             (hot_ring),
    .witness_valid        (witness_valid),
    .witness_kind         (witness_kind),
    .witness_ring         (witness_ring),
    .witness_tag          (witness_tag),
    .current_special_ring (current_special_ring)
  );

endmodule
